@@ rtl/npcs_pkg.sv @@
package npcs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int SYSTEM_SKIP     = 10;
  localparam int COLOR_W         = 8;
  localparam int ENTRY_W         = 3 * COLOR_W;
  localparam int INDEX_W         = 8;
  localparam int SQ_W            = 2 * COLOR_W;
  localparam int DIST_W          = 18;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [PAL_AW-1:0]  pal_addr_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [SQ_W-1:0]    sq_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  function automatic sq_t square_diff(color_t a, color_t b);
    color_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

@@ rtl/npcs_if.sv @@
interface npcs_req_if;
  import npcs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [INDEX_W-1:0]   entry_index;
  color_t               red;
  color_t               green;
  color_t               blue;
  logic                 skip_system_entries;

  modport source (
    output valid, req_type, entry_index, red, green, blue, skip_system_entries,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, red, green, blue, skip_system_entries,
    output ready
  );
endinterface

interface npcs_rsp_if;
  import npcs_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] best_index;
  dist_t              best_distance;

  modport source (
    output valid, best_index, best_distance,
    input  ready
  );
  modport sink (
    input  valid, best_index, best_distance,
    output ready
  );
endinterface

@@ rtl/npcs_ram.sv @@
module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ rtl/nearest_palette_color_search.sv @@
// write transaction: accepted only in idle, no result
// query transaction: result registered once the search over N entries and the drain are done, N = entries searched
//   (PALETTE_ENTRIES, or PALETTE_ENTRIES - 20 with system entries skipped)
// a new request is taken only in idle, after the last result is loaded; the single distance unit reads one
//   palette entry per cycle from the one read port of the palette ram
// reset: synchronous active low; per-entry valid bits clear so the palette reads zero at once
module nearest_palette_color_search (
  input  logic       clk,
  input  logic       rst_n,
  npcs_req_if.sink   in_req,
  npcs_rsp_if.source out_rsp
);
  import npcs_pkg::*;

  localparam pal_addr_t FULL_FIRST = '0;
  localparam pal_addr_t FULL_LAST  = PAL_AW'(PALETTE_ENTRIES - 1);
  localparam pal_addr_t SKIP_FIRST = PAL_AW'(SYSTEM_SKIP);
  localparam pal_addr_t SKIP_LAST  = PAL_AW'(PALETTE_ENTRIES - SYSTEM_SKIP - 1);

  state_t    state_r, state_nxt;
  pal_addr_t rd_idx_r, rd_idx_nxt;
  pal_addr_t last_idx_r, last_idx_nxt;
  logic      first_pend_r, first_pend_nxt;
  color_t    tgt_red_r, tgt_green_r, tgt_blue_r;

  logic                      valid_r [PALETTE_ENTRIES];

  logic      s1_valid_r, s1_first_r, s1_last_r, s1_vld_r;
  pal_addr_t s1_idx_r;
  logic      s2_valid_r, s2_first_r, s2_last_r;
  pal_addr_t s2_idx_r;
  sq_t       sq_red_r, sq_green_r, sq_blue_r;

  pal_addr_t best_idx_r;
  dist_t     best_dist_r;

  logic               out_valid_r;
  logic [INDEX_W-1:0] out_index_r;
  dist_t              out_dist_r;

  logic                 in_acc;
  logic                 wr_en;
  pal_addr_t            wr_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic [ENTRY_W-1:0]   entry;
  logic                 issue;
  logic                 out_load;
  dist_t                dist_sum;
  logic                 take;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign wr_en        = in_acc && (in_req.req_type == REQ_WRITE) &&
                        ({1'b0, in_req.entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));
  assign wr_addr      = in_req.entry_index[PAL_AW-1:0];
  assign issue        = (state_r == ST_SEARCH);

  npcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_req.red, in_req.green, in_req.blue}),
    .re    (issue),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  // entries never written read as zero
  assign entry = s1_vld_r ? rd_data : '0;

  assign dist_sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);
  assign take     = s2_valid_r && (s2_first_r || (dist_sum < best_dist_r));

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    last_idx_nxt   = last_idx_r;
    first_pend_nxt = first_pend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_req.req_type == REQ_QUERY)) begin
          rd_idx_nxt     = in_req.skip_system_entries ? SKIP_FIRST : FULL_FIRST;
          last_idx_nxt   = in_req.skip_system_entries ? SKIP_LAST : FULL_LAST;
          first_pend_nxt = 1'b1;
          state_nxt      = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        first_pend_nxt = 1'b0;
        if (rd_idx_r == last_idx_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (s2_valid_r && s2_last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_idx_r     <= '0;
      last_idx_r   <= '0;
      first_pend_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      rd_idx_r     <= rd_idx_nxt;
      last_idx_r   <= last_idx_nxt;
      first_pend_r <= first_pend_nxt;
      s1_valid_r   <= issue;
      s2_valid_r   <= s1_valid_r;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath: target latch, read tag, squares, running best, output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_red_r   <= in_req.red;
      tgt_green_r <= in_req.green;
      tgt_blue_r  <= in_req.blue;
    end
    s1_first_r <= first_pend_r;
    s1_last_r  <= (rd_idx_r == last_idx_r);
    s1_idx_r   <= rd_idx_r;
    s1_vld_r   <= valid_r[rd_idx_r];
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_idx_r   <= s1_idx_r;
    sq_red_r   <= square_diff(entry[3*COLOR_W-1:2*COLOR_W], tgt_red_r);
    sq_green_r <= square_diff(entry[2*COLOR_W-1:COLOR_W], tgt_green_r);
    sq_blue_r  <= square_diff(entry[COLOR_W-1:0], tgt_blue_r);
    if (take) begin
      best_idx_r  <= s2_idx_r;
      best_dist_r <= dist_sum;
    end
    if (out_load) begin
      out_index_r <= INDEX_W'(best_idx_r);
      out_dist_r  <= best_dist_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.best_index    = out_index_r;
  assign out_rsp.best_distance = out_dist_r;

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

  a_cmp_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (state_r == ST_SEARCH || state_r == ST_DRAIN))
    else $error("distance compare outside a query");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (rd_idx_r <= last_idx_r))
    else $error("search index past end of range");

  a_first_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_first_r) |-> $past(state_r == ST_SEARCH, 1) &&
                                   $past(state_r == ST_IDLE, 2))
    else $error("first read not right after query acceptance");

endmodule

@@ bench/nearest_color_checker.sv @@
`timescale 1ns / 1ps
module nearest_color_checker (
  input  logic clk,
  input  logic rst_n,
  npcs_req_if  req_ch,
  npcs_rsp_if  rsp_ch,
  output int   fail_count,
  output int   pending,
  output int   writes_seen,
  output int   queries_seen,
  output int   skip_queries,
  output int   results_checked
);
  import npcs_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    dist_t              distance;
  } nearest_t;

  logic [ENTRY_W-1:0] palette_mirror [PALETTE_ENTRIES];
  nearest_t           nearest_queue [$];

  function automatic dist_t rgb_distance(logic [ENTRY_W-1:0] entry, color_t r, color_t g,
                                         color_t b);
    int dr, dg, db;
    dr = int'(entry[23:16]) - int'(r);
    dg = int'(entry[15:8]) - int'(g);
    db = int'(entry[7:0]) - int'(b);
    return dist_t'(dr * dr + dg * dg + db * db);
  endfunction

  function automatic nearest_t find_nearest(color_t r, color_t g, color_t b, logic skip);
    nearest_t best;
    dist_t    d;
    int       lo, hi;
    lo = skip ? SYSTEM_SKIP : 0;
    hi = skip ? PALETTE_ENTRIES - SYSTEM_SKIP : PALETTE_ENTRIES;
    best.index    = INDEX_W'(lo);
    best.distance = rgb_distance(palette_mirror[lo], r, g, b);
    for (int i = lo + 1; i < hi; i++) begin
      d = rgb_distance(palette_mirror[i], r, g, b);
      // strict compare keeps the lowest index on a tie
      if (d < best.distance) begin
        best.distance = d;
        best.index    = INDEX_W'(i);
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] checker: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    nearest_t want;
    if (!rst_n) begin
      foreach (palette_mirror[i]) palette_mirror[i] = '0;
      nearest_queue.delete();
      pending = 0;
    end else begin
      // results first: a result never belongs to a query taken in the same cycle
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (nearest_queue.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: index %0d distance %0d",
                                    rsp_ch.best_index, rsp_ch.best_distance));
        end else begin
          want = nearest_queue.pop_front();
          results_checked++;
          if (rsp_ch.best_index !== want.index)
            report_mismatch($sformatf("best_index %0d, expected %0d",
                                      rsp_ch.best_index, want.index));
          if (rsp_ch.best_distance !== want.distance)
            report_mismatch($sformatf("best_distance %0d, expected %0d",
                                      rsp_ch.best_distance, want.distance));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.req_type == REQ_WRITE) begin
          writes_seen++;
          if (req_ch.entry_index < PALETTE_ENTRIES)
            palette_mirror[req_ch.entry_index] = {req_ch.red, req_ch.green, req_ch.blue};
        end else begin
          queries_seen++;
          if (req_ch.skip_system_entries) skip_queries++;
          nearest_queue.push_back(find_nearest(req_ch.red, req_ch.green, req_ch.blue,
                                               req_ch.skip_system_entries));
        end
      end
      pending = nearest_queue.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import npcs_pkg::*;

  localparam int RANDOM_ITEMS    = 1600;
  localparam int PRESSURE_START  = 8000;
  localparam int PRESSURE_CYCLES = 2000;
  localparam int IDLE_LIMIT      = 10000;
  localparam int DRAIN_CYCLES    = 2 * PALETTE_ENTRIES + 8;

  typedef struct {
    logic               req_type;
    logic [INDEX_W-1:0] entry_index;
    color_t             red;
    color_t             green;
    color_t             blue;
    logic               skip;
  } palette_txn_t;

  logic clk;
  logic rst_n;

  npcs_req_if in_ch();
  npcs_rsp_if out_ch();

  palette_txn_t       txn_queue [$];
  logic [ENTRY_W-1:0] written_rgb [PALETTE_ENTRIES];

  int          fail_count, pending, writes_seen, queries_seen, skip_queries, results_checked;
  int          burst_left, gap_left, rx_cycle, hold_left, idle_cycles;
  logic [31:0] ready_pattern;

  nearest_palette_color_search u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_rsp (out_ch)
  );

  nearest_color_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ch          (in_ch),
    .rsp_ch          (out_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .writes_seen     (writes_seen),
    .queries_seen    (queries_seen),
    .skip_queries    (skip_queries),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic color_t pick_component();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return color_t'($urandom);
    endcase
  endfunction

  function automatic void queue_write(int idx, color_t r, color_t g, color_t b);
    palette_txn_t t;
    t.req_type    = REQ_WRITE;
    t.entry_index = INDEX_W'(idx);
    t.red         = r;
    t.green       = g;
    t.blue        = b;
    t.skip        = 1'($urandom);
    txn_queue.push_back(t);
    written_rgb[idx] = {r, g, b};
  endfunction

  function automatic void queue_query(color_t r, color_t g, color_t b, logic skip);
    palette_txn_t t;
    t.req_type    = REQ_QUERY;
    t.entry_index = INDEX_W'($urandom);
    t.red         = r;
    t.green       = g;
    t.blue        = b;
    t.skip        = skip;
    txn_queue.push_back(t);
  endfunction

  // sender: bursts of random length, random gaps, some bursts back to back
  always @(posedge clk) begin
    palette_txn_t t;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0 || txn_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        t = txn_queue.pop_front();
        in_ch.valid               <= 1'b1;
        in_ch.req_type            <= t.req_type;
        in_ch.entry_index         <= t.entry_index;
        in_ch.red                 <= t.red;
        in_ch.green               <= t.green;
        in_ch.blue                <= t.blue;
        in_ch.skip_system_entries <= t.skip;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 23);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // receiver: random ready pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cycle      = 0;
      hold_left     = 0;
      ready_pattern = '1;
    end else begin
      rx_cycle++;
      if (rx_cycle == PRESSURE_START) hold_left = PRESSURE_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_cycle % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: ready_pattern = '1;
            1: ready_pattern = $urandom;
            default: ready_pattern = $urandom | $urandom;
          endcase
        end
        out_ch.ready <= ready_pattern[rx_cycle % 32];
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                 pick;
    int                 idx;
    logic [ENTRY_W-1:0] base;
    rst_n                     = 1'b0;
    in_ch.valid               = 1'b0;
    in_ch.req_type            = REQ_WRITE;
    in_ch.entry_index         = '0;
    in_ch.red                 = '0;
    in_ch.green               = '0;
    in_ch.blue                = '0;
    in_ch.skip_system_entries = 1'b0;
    out_ch.ready              = 1'b0;
    foreach (written_rgb[i]) written_rgb[i] = '0;

    // cleared palette: ties everywhere, lowest index of each range wins
    queue_query(8'h00, 8'h00, 8'h00, 1'b0);
    queue_query(8'hff, 8'hff, 8'hff, 1'b1);
    // entries at and just outside the edges of the skipped range
    queue_write(0, 8'hff, 8'hff, 8'hff);
    queue_write(PALETTE_ENTRIES - 1, 8'hff, 8'h00, 8'hff);
    queue_write(SYSTEM_SKIP - 1, 8'h80, 8'h80, 8'h80);
    queue_write(PALETTE_ENTRIES - SYSTEM_SKIP, 8'h01, 8'h02, 8'h03);
    queue_write(SYSTEM_SKIP, 8'h7f, 8'h7f, 8'h7f);
    queue_write(PALETTE_ENTRIES - SYSTEM_SKIP - 1, 8'hfe, 8'hfe, 8'hfe);
    queue_query(8'hff, 8'hff, 8'hff, 1'b0);
    queue_query(8'hff, 8'hff, 8'hff, 1'b1);
    queue_query(8'hff, 8'h00, 8'hff, 1'b0);
    queue_query(8'hff, 8'h00, 8'hff, 1'b1);
    queue_query(8'h80, 8'h80, 8'h80, 1'b1);
    queue_query(8'h01, 8'h02, 8'h03, 1'b0);
    queue_query(8'h00, 8'h00, 8'h00, 1'b1);
    // exact tie between two non-zero entries
    queue_write(SYSTEM_SKIP + 1, 8'haa, 8'h55, 8'haa);
    queue_write(SYSTEM_SKIP + 2, 8'haa, 8'h55, 8'haa);
    queue_query(8'haa, 8'h55, 8'haa, 1'b1);
    queue_query(8'h55, 8'haa, 8'h55, 1'b0);
    queue_write(PALETTE_ENTRIES / 2, 8'h00, 8'hff, 8'h00);
    queue_query(8'h00, 8'hff, 8'h00, 1'b1);

    // fill the whole palette, with some duplicated colors for ties
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        base = written_rgb[$urandom_range(0, i - 1)];
        queue_write(i, base[23:16], base[15:8], base[7:0]);
      end else begin
        queue_write(i, pick_component(), pick_component(), pick_component());
      end
    end

    repeat (RANDOM_ITEMS - PALETTE_ENTRIES) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        if ($urandom_range(0, 3) == 0)
          idx = $urandom_range(0, 1) ? $urandom_range(0, SYSTEM_SKIP - 1)
                                     : $urandom_range(PALETTE_ENTRIES - SYSTEM_SKIP,
                                                      PALETTE_ENTRIES - 1);
        else
          idx = $urandom_range(0, PALETTE_ENTRIES - 1);
        if ($urandom_range(0, 5) == 0) begin
          base = written_rgb[$urandom_range(0, PALETTE_ENTRIES - 1)];
          queue_write(idx, base[23:16], base[15:8], base[7:0]);
        end else begin
          queue_write(idx, pick_component(), pick_component(), pick_component());
        end
      end else begin
        base = written_rgb[$urandom_range(0, PALETTE_ENTRIES - 1)];
        case (pick)
          6: queue_query(base[23:16], base[15:8], base[7:0], 1'($urandom));
          7: queue_query(base[23:16] ^ 8'($urandom_range(0, 3)),
                         base[15:8] ^ 8'($urandom_range(0, 3)),
                         base[7:0] ^ 8'($urandom_range(0, 3)), 1'($urandom));
          default: queue_query(pick_component(), pick_component(), pick_component(),
                               1'($urandom));
        endcase
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (txn_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d palette writes, %0d searches (%0d skipping system entries), %0d checked",
             writes_seen, queries_seen, skip_queries, results_checked);
    $display("run: bursty sender, random result stalls and one %0d-cycle result hold-off",
             PRESSURE_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
